FILE: sv/xcrc_pkg.sv
// Package for the XMODEM-CRC packet receiver.
// Holds the beat types, the protocol constants and the CRC byte update.
// No dependencies.
package xcrc_pkg;

    localparam int PAGE_BYTES_DEF  = 1024;
    localparam int MAX_PACKETS_DEF = 1024;
    localparam int BLOCK_LEN       = 128;

    localparam logic [15:0] CRC_GEN_POLY = 16'h1021;
    localparam logic [15:0] CRC_SEED     = 16'h0000;
    localparam logic [15:0] CRC_MSB      = 16'h8000;
    localparam logic [7:0]  HDR_SOH      = 8'h01;
    localparam logic [7:0]  HDR_EOT      = 8'h04;

    // Frame positions: payload spans POS_DATA_FIRST..POS_DATA_LAST.
    localparam logic [7:0] POS_DATA_FIRST = 8'd3;
    localparam logic [7:0] POS_DATA_LAST  = 8'd130;
    localparam logic [7:0] POS_CRC_HIGH   = 8'd131;
    localparam logic [7:0] POS_CRC_LOW    = 8'd132;
    localparam logic [7:0] POS_MAX        = 8'd255;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_ACK     = 3'd2;
    localparam logic [2:0] KIND_NAK     = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload;
        logic [16:0] byte_address;
        logic        page_ready;
        logic [6:0]  page_index;
        logic [9:0]  tail_bytes;
    } t_out_item;

    typedef enum logic {
        OP_START = 1'b0,
        OP_BYTE  = 1'b1
    } t_op;

    // Classified beat handed from the front end to the back end.
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
        logic       is_soh;
        logic       is_eot;
    } t_beat;

    // CRC-16/XMODEM update for one byte, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = (c << 1) ^ CRC_GEN_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/xcrc_front.sv
// Front end of the XMODEM-CRC receiver: classifies each input beat.
// Depends on xcrc_pkg.
module xcrc_front (
    input  xcrc_pkg::t_in_item i_item,
    output xcrc_pkg::t_beat    o_beat
);
    import xcrc_pkg::*;

    always_comb begin
        o_beat.op     = i_item.command ? OP_BYTE : OP_START;
        o_beat.data   = i_item.rx_byte;
        o_beat.last   = i_item.frame_end;
        o_beat.is_soh = (i_item.rx_byte == HDR_SOH);
        o_beat.is_eot = (i_item.rx_byte == HDR_EOT);
    end

endmodule

FILE: sv/xcrc_queue.sv
// Two-entry queue between the front and back ends of the receiver.
// Depends on xcrc_pkg.
module xcrc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xcrc_pkg::t_beat i_beat,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output xcrc_pkg::t_beat o_beat
);
    import xcrc_pkg::*;

    t_beat      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_beat  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: sv/xcrc_back.sv
// Back end of the receiver: frame tracking, CRC check, packet and page counting,
// and the output register. Depends on xcrc_pkg.
module xcrc_back #(
    parameter int PAGE_BYTES  = xcrc_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PACKETS = xcrc_pkg::MAX_PACKETS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  xcrc_pkg::t_beat    i_beat,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output xcrc_pkg::t_out_item o_out_item
);
    import xcrc_pkg::*;

    localparam int PktsPerPage = (PAGE_BYTES / BLOCK_LEN == 0) ? 1 : PAGE_BYTES / BLOCK_LEN;
    localparam int PktW        = ($clog2(PktsPerPage) > 0) ? $clog2(PktsPerPage) : 1;
    localparam int LimitRaw    = (MAX_PACKETS > 0) ? MAX_PACKETS - 1 : 0;
    localparam int CountLimit  = (LimitRaw > 1023) ? 1023 : LimitRaw;

    logic            r_armed,    n_armed;
    logic [7:0]      r_len,      n_len;
    logic            r_hdr,      n_hdr;
    logic [15:0]     r_crc,      n_crc;
    logic [7:0]      r_crc_hi,   n_crc_hi;
    logic [9:0]      r_good,     n_good;
    // Running quotient and remainder of the good count by packets per page.
    logic [9:0]      r_page_cnt, n_page_cnt;
    logic [PktW-1:0] r_pkt,      n_pkt;

    logic            r_out_valid;
    t_out_item       r_out;
    t_out_item       w_out;
    logic            w_fire;
    logic            w_hdr;
    logic [7:0]      w_off;
    logic [16:0]     w_tail;

    assign o_pop       = !r_out_valid || i_out_ready;
    assign w_fire      = i_valid && o_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_off       = r_len - POS_DATA_FIRST;
    assign w_tail      = {10'(r_pkt), 7'b0};

    always_comb begin
        n_armed    = r_armed;
        n_len      = r_len;
        n_hdr      = r_hdr;
        n_crc      = r_crc;
        n_crc_hi   = r_crc_hi;
        n_good     = r_good;
        n_page_cnt = r_page_cnt;
        n_pkt      = r_pkt;
        w_out      = '0;
        w_hdr      = r_hdr;

        if (w_fire) begin
            case (i_beat.op)
                OP_START: begin
                    n_armed    = 1'b1;
                    n_good     = '0;
                    n_page_cnt = '0;
                    n_pkt      = '0;
                    n_len      = '0;
                    n_hdr      = 1'b0;
                    n_crc      = CRC_SEED;
                    n_crc_hi   = '0;
                end
                OP_BYTE: begin
                    if (r_len == 8'd0) begin
                        w_hdr = i_beat.is_soh;
                    end
                    n_hdr = w_hdr;
                    if (r_len >= POS_DATA_FIRST && r_len <= POS_DATA_LAST) begin
                        n_crc = crc_byte(r_crc, i_beat.data);
                        if (r_armed && w_hdr) begin
                            w_out.kind         = KIND_PAYLOAD;
                            w_out.payload      = i_beat.data;
                            w_out.byte_address = {r_good, w_off[6:0]};
                        end
                    end
                    if (r_len == POS_CRC_HIGH) begin
                        n_crc_hi = i_beat.data;
                    end
                    if (i_beat.last) begin
                        if (r_armed && r_len == 8'd0 && i_beat.is_eot) begin
                            w_out.kind       = KIND_END;
                            w_out.page_index = r_page_cnt[6:0];
                            w_out.tail_bytes = w_tail[9:0];
                            n_armed          = 1'b0;
                        end else if (r_armed && r_len == POS_CRC_LOW && w_hdr) begin
                            if ({r_crc_hi, i_beat.data} == r_crc) begin
                                w_out.kind = KIND_ACK;
                                if (r_good < 10'(CountLimit)) begin
                                    n_good = r_good + 10'd1;
                                    if (r_pkt == PktW'(PktsPerPage - 1)) begin
                                        // This packet closes a page.
                                        w_out.page_ready = 1'b1;
                                        w_out.page_index = r_page_cnt[6:0];
                                        n_page_cnt       = r_page_cnt + 10'd1;
                                        n_pkt            = '0;
                                    end else begin
                                        n_pkt = r_pkt + PktW'(1);
                                    end
                                end
                            end else begin
                                w_out.kind = KIND_NAK;
                            end
                        end
                        n_len    = '0;
                        n_hdr    = 1'b0;
                        n_crc    = CRC_SEED;
                        n_crc_hi = '0;
                    end else if (r_len < POS_MAX) begin
                        n_len = r_len + 8'd1;
                    end
                end
                default: begin
                    n_armed = r_armed;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_len       <= '0;
            r_hdr       <= 1'b0;
            r_crc       <= CRC_SEED;
            r_crc_hi    <= '0;
            r_good      <= '0;
            r_page_cnt  <= '0;
            r_pkt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_armed    <= n_armed;
            r_len      <= n_len;
            r_hdr      <= n_hdr;
            r_crc      <= n_crc;
            r_crc_hi   <= n_crc_hi;
            r_good     <= n_good;
            r_page_cnt <= n_page_cnt;
            r_pkt      <= n_pkt;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_out;
        end
    end

endmodule

FILE: sv/xmodem_crc_packet_receiver.sv
// Top level of the XMODEM-CRC packet receiver.
// Depends on xcrc_pkg, xcrc_front, xcrc_queue and xcrc_back.
//
// Input channel (i_in_valid / o_in_ready / i_in_item): one beat is either a
// start command or one received byte with its end-of-frame mark.
// Output channel (o_out_valid / i_out_ready / o_out_item): exactly one result
// beat per input beat, in order; kind 0 results are delivered too.
//
// A beat is classified on entry and written into a two-entry queue. The back
// end pops one beat per cycle unless the receiver stalls, updates the frame
// state and CRC, and loads the output register. An accepted beat passes the
// queue register and then the output register before o_out_valid rises; with the
// receiver ready, throughput is one beat per cycle (combinational CRC update).
//
// Reset empties the queue and clears the output valid flag, the session and all counters.
// When the receiver stalls, the output register holds its beat, the back end
// stops popping, and o_in_ready falls once the queue holds two beats.
module xmodem_crc_packet_receiver #(
    parameter int PAGE_BYTES  = xcrc_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PACKETS = xcrc_pkg::MAX_PACKETS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  xcrc_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output xcrc_pkg::t_out_item o_out_item
);
    import xcrc_pkg::*;

    t_beat w_front_beat;
    t_beat w_q_beat;
    logic  w_q_full;
    logic  w_q_valid;
    logic  w_pop;

    assign o_in_ready = !w_q_full;

    xcrc_front u_front (
        .i_item (i_in_item),
        .o_beat (w_front_beat)
    );

    xcrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_beat  (w_front_beat),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_beat  (w_q_beat)
    );

    xcrc_back #(
        .PAGE_BYTES  (PAGE_BYTES),
        .MAX_PACKETS (MAX_PACKETS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_beat      (w_q_beat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: sv/xcrc_checker.sv
// Port-level checker for the XMODEM-CRC packet receiver, bound to the top level.
// Depends on xcrc_pkg.
module xcrc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input xcrc_pkg::t_out_item o_out_item
);
    import xcrc_pkg::*;

    // A result beat waiting on the receiver holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present right after reset");

    // Payload and address fields are zero except on a payload beat.
    a_payload_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind != KIND_PAYLOAD |->
            o_out_item.payload == 8'd0 && o_out_item.byte_address == 17'd0)
        else $error("payload fields set on a non-payload beat");

    a_page_on_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.page_ready |-> o_out_item.kind == KIND_ACK)
        else $error("page_ready outside an ack");

    a_tail_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.tail_bytes != 10'd0 |-> o_out_item.kind == KIND_END)
        else $error("tail_bytes outside an end beat");

endmodule

bind xmodem_crc_packet_receiver xcrc_checker u_xcrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
